>>> design/dqfr_pkg.sv
// ----------------------------------------------------------------------------
// DNS query filter responder package
// Shared sizes, codes, request descriptor and byte tables.
// ----------------------------------------------------------------------------
package dqfr_pkg;

   localparam int PACKET_BYTES  = 512;
   localparam int DOMAIN_SLOTS  = 16;
   localparam int NAME_BYTES    = 256;
   localparam int POINTER_DEPTH = 10;

   localparam int PKT_AW   = $clog2(PACKET_BYTES);
   localparam int FILL_W   = $clog2(PACKET_BYTES + 1);
   localparam int NAME_AW  = $clog2(NAME_BYTES);
   localparam int LEN_W    = NAME_AW + 1;
   localparam int SLOT_W   = $clog2(DOMAIN_SLOTS + 1);
   localparam int SLOT_AW  = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
   localparam int DOM_AW   = SLOT_AW + NAME_AW;
   localparam int DOM_DEPTH = (1 << SLOT_AW) * (1 << NAME_AW);
   localparam int DEPTH_W  = $clog2(POINTER_DEPTH + 1);
   localparam int POS_W    = 14;
   localparam int HDR_BYTES = 12;
   localparam int RESP_FIXED = 33;
   localparam int TAIL_LAST = 20;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_DOMAIN = 2'd1;
   localparam logic [1:0] ACT_PACKET = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOMATCH   = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;
   localparam logic [1:0] ST_OVERSIZED = 2'd3;

   localparam logic [7:0] PTR_MARK  = 8'hC0;
   localparam logic [7:0] LABEL_MAX = 8'h3F;
   localparam logic [7:0] DOT       = 8'h2E;

   typedef struct packed {
      logic              over;
      logic [FILL_W-1:0] fill;
   } job_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   // Header bytes after the ID: flags 0x8180, qdcount 1, ancount 1, rest zero.
   function automatic logic [7:0] hdr_byte(input logic [3:0] k);
      logic [7:0] b;
      case (k)
         4'd0: b = 8'h81;
         4'd1: b = 8'h80;
         4'd3: b = 8'h01;
         4'd5: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Name terminator, QTYPE/QCLASS, answer record and its address.
   function automatic logic [7:0] tail_byte(input logic [4:0] k, input logic [31:0] addr);
      logic [7:0] b;
      case (k)
         5'd2:  b = 8'h01;
         5'd4:  b = 8'h01;
         5'd5:  b = 8'hC0;
         5'd6:  b = 8'h0C;
         5'd8:  b = 8'h01;
         5'd10: b = 8'h01;
         5'd14: b = 8'd60;
         5'd16: b = 8'h04;
         5'd17: b = addr[31:24];
         5'd18: b = addr[23:16];
         5'd19: b = addr[15:8];
         5'd20: b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> design/dqfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/dqfr_front.sv
// ----------------------------------------------------------------------------
// DNS filter front end
// Writes packet and domain bytes and hands finished packets to the queue.
// ----------------------------------------------------------------------------
module dqfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    req_action,
   input  logic                          req_end_mark,
   output logic                          pkt_we,
   output logic [dqfr_pkg::PKT_AW-1:0]   pkt_waddr,
   output logic                          dom_we,
   output logic [dqfr_pkg::DOM_AW-1:0]   dom_waddr,
   output logic                          push,
   output dqfr_pkg::job_type             job,
   input  logic [dqfr_pkg::SLOT_AW-1:0]  len_idx,
   output logic [dqfr_pkg::LEN_W-1:0]    len_out,
   output logic [dqfr_pkg::SLOT_W-1:0]   count
);
   import dqfr_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              over_ff, over_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]  lengths_ff [DOMAIN_SLOTS];
   logic              is_pkt, is_dom, is_clr, room, slot_free;

   assign is_pkt    = accept && req_action == ACT_PACKET;
   assign is_dom    = accept && req_action == ACT_DOMAIN;
   assign is_clr    = accept && req_action == ACT_CLEAR;
   assign room      = fill_ff < FILL_W'(PACKET_BYTES);
   assign slot_free = count_ff < SLOT_W'(DOMAIN_SLOTS);

   assign pkt_we    = is_pkt && room;
   assign pkt_waddr = fill_ff[PKT_AW-1:0];
   assign dom_we    = is_dom && slot_free && cur_len_ff < LEN_W'(NAME_BYTES - 1);
   assign dom_waddr = {count_ff[SLOT_AW-1:0], cur_len_ff[NAME_AW-1:0]};

   assign push      = is_pkt && req_end_mark;
   assign job.fill  = room ? fill_ff + FILL_W'(1) : fill_ff;
   assign job.over  = over_ff || !room;

   assign len_out = (32'(len_idx) < DOMAIN_SLOTS) ? lengths_ff[len_idx] : '0;
   assign count   = count_ff;

   always_comb begin
      fill_in    = fill_ff;
      over_in    = over_ff;
      count_in   = count_ff;
      cur_len_in = cur_len_ff;
      if (is_pkt) begin
         if (req_end_mark) begin
            fill_in = '0;
            over_in = 1'b0;
         end else if (room) begin
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            over_in = 1'b1;
         end
      end
      if (is_clr) begin
         count_in   = '0;
         cur_len_in = '0;
      end
      if (is_dom && slot_free) begin
         if (dom_we) begin
            cur_len_in = cur_len_ff + LEN_W'(1);
         end
         if (req_end_mark) begin
            count_in   = count_ff + SLOT_W'(1);
            cur_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         over_ff    <= 1'b0;
         count_ff   <= '0;
         cur_len_ff <= '0;
         for (int i = 0; i < DOMAIN_SLOTS; i++) begin
            lengths_ff[i] <= '0;
         end
      end else begin
         fill_ff    <= fill_in;
         over_ff    <= over_in;
         count_ff   <= count_in;
         cur_len_ff <= cur_len_in;
         if (is_clr) begin
            for (int i = 0; i < DOMAIN_SLOTS; i++) begin
               lengths_ff[i] <= '0;
            end
         end else if (dom_we) begin
            lengths_ff[count_ff[SLOT_AW-1:0]] <= cur_len_ff + LEN_W'(1);
         end
      end
   end

endmodule

>>> design/dqfr_queue.sv
// ----------------------------------------------------------------------------
// DNS filter packet queue
// Two-entry queue of finished packet descriptors between front and back.
// ----------------------------------------------------------------------------
module dqfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dqfr_pkg::job_type push_job,
   input  logic              pop,
   output dqfr_pkg::job_type head,
   output logic              empty
);
   import dqfr_pkg::*;

   job_type    ent_ff [2];
   logic       rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic       full;

   assign empty = cnt_ff == 2'd0;
   assign full  = cnt_ff == 2'd2;
   assign head  = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         ent_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ff <= ~wr_ff;
         end
         if (pop && !empty) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("packet queue overflow");

endmodule

>>> design/dqfr_back.sv
// ----------------------------------------------------------------------------
// DNS filter back end
// Checks, decodes and matches one packet; emits response words or a status.
// ----------------------------------------------------------------------------
module dqfr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_ready,
   input  dqfr_pkg::job_type             job,
   output logic                          pop,
   output logic                          active,
   input  logic [31:0]                   spoof_address,
   input  logic [dqfr_pkg::SLOT_W-1:0]   count,
   output logic [dqfr_pkg::SLOT_AW-1:0]  len_idx,
   input  logic [dqfr_pkg::LEN_W-1:0]    len_in,
   output logic [dqfr_pkg::PKT_AW-1:0]   pkt_raddr,
   input  logic [7:0]                    pkt_rdata,
   output logic [dqfr_pkg::DOM_AW-1:0]   dom_raddr,
   input  logic [7:0]                    dom_rdata,
   output logic                          rsp_valid,
   output logic [63:0]                   rsp_data_word,
   output logic [3:0]                    rsp_byte_count,
   output logic                          rsp_final_word,
   output logic [1:0]                    rsp_status,
   output logic [8:0]                    rsp_response_length
);
   import dqfr_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0,  S_CHK = 5'd1,  S_H4 = 5'd2,   S_H5 = 5'd3;
   localparam logic [4:0] S_LAB = 5'd4,   S_LAB_D = 5'd5, S_PTR_D = 5'd6, S_CPY = 5'd7;
   localparam logic [4:0] S_CPY_D = 5'd8, S_NEND = 5'd9,  S_QT = 5'd10,  S_QT_D = 5'd11;
   localparam logic [4:0] S_LD = 5'd12,   S_LD_D = 5'd13, S_SLOT = 5'd14, S_DOT_D = 5'd15;
   localparam logic [4:0] S_CMP = 5'd16,  S_CMP_D = 5'd17, S_RESP = 5'd18, S_ID = 5'd19;
   localparam logic [4:0] S_ID_D = 5'd20, S_HDR = 5'd21,  S_NM = 5'd22,  S_SCAN = 5'd23;
   localparam logic [4:0] S_SCAN_D = 5'd24, S_LEN = 5'd25, S_NCP = 5'd26, S_NCP_D = 5'd27;
   localparam logic [4:0] S_TL = 5'd28;

   logic [4:0]         state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               over_ff, over_in;
   logic               z4_ff, z4_in;
   logic [POS_W-1:0]   pos_ff, pos_in, after_ff, after_in;
   logic [LEN_W-1:0]   w_ff, w_in, seg_ff, seg_in, nlen_ff, nlen_in;
   logic [LEN_W-1:0]   q_ff, q_in, m_ff, m_in, off_ff, off_in, k_ff, k_in;
   logic [LEN_W-1:0]   e_ff, e_in, p_ff, p_in;
   logic [8:0]         rlen_ff, rlen_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               jumped_ff, jumped_in, last_dot_ff, last_dot_in;
   logic [5:0]         lab_ff, lab_in, cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic [POS_W-1:0]   fill_x, tgt;
   logic               st_go, push_en, push_last;
   logic [1:0]         st_code;
   logic [7:0]         push_byte;
   logic               nm_we;
   logic [NAME_AW-1:0] nm_waddr, nm_raddr;
   logic [7:0]         nm_wdata, nm_rdata;

   logic [63:0]        acc_ff, acc_in;
   logic [2:0]         bcnt_ff;
   logic               valid_ff;
   logic [63:0]        word_ff;
   logic [3:0]         bc_ff;
   logic               fin_ff;
   logic [1:0]         stat_ff;
   logic [8:0]         len_ff;

   dqfr_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
      .clock (clock),
      .we    (nm_we),
      .waddr (nm_waddr),
      .wdata (nm_wdata),
      .raddr (nm_raddr),
      .rdata (nm_rdata)
   );

   assign fill_x  = POS_W'(fill_ff);
   assign tgt     = {lab_ff, pkt_rdata};
   assign active  = state_ff != S_IDLE;
   assign len_idx = slot_ff[SLOT_AW-1:0];

   always_comb begin
      state_in = state_ff;   fill_in = fill_ff;     over_in = over_ff;   z4_in = z4_ff;
      pos_in = pos_ff;       after_in = after_ff;   w_in = w_ff;         seg_in = seg_ff;
      nlen_in = nlen_ff;     q_in = q_ff;           m_in = m_ff;         off_in = off_ff;
      k_in = k_ff;           e_in = e_ff;           p_in = p_ff;         rlen_in = rlen_ff;
      depth_in = depth_ff;   jumped_in = jumped_ff; last_dot_in = last_dot_ff;
      lab_in = lab_ff;       cnt_in = cnt_ff;       slot_in = slot_ff;
      pop = 1'b0;
      st_go = 1'b0;          st_code = ST_MALFORMED;
      push_en = 1'b0;        push_last = 1'b0;      push_byte = 8'h00;
      pkt_raddr = '0;        dom_raddr = '0;        nm_raddr = '0;
      nm_we = 1'b0;          nm_waddr = w_ff[NAME_AW-1:0]; nm_wdata = DOT;

      case (state_ff)
         S_IDLE: begin
            if (job_ready) begin
               pop      = 1'b1;
               fill_in  = job.fill;
               over_in  = job.over;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (over_ff) begin
               st_go = 1'b1; st_code = ST_OVERSIZED; state_in = S_IDLE;
            end else if (fill_ff < FILL_W'(HDR_BYTES)) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               pkt_raddr = PKT_AW'(4);
               state_in  = S_H4;
            end
         end
         S_H4: begin
            z4_in     = pkt_rdata == 8'h00;
            pkt_raddr = PKT_AW'(5);
            state_in  = S_H5;
         end
         S_H5: begin
            if (z4_ff && pkt_rdata == 8'h00) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               pos_in = POS_W'(HDR_BYTES); w_in = '0; seg_in = '0;
               depth_in = '0; jumped_in = 1'b0;
               state_in = S_LAB;
            end
         end
         S_LAB: begin
            if (pos_ff >= fill_x) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               pkt_raddr = pos_ff[PKT_AW-1:0];
               pos_in    = pos_ff + POS_W'(1);
               state_in  = S_LAB_D;
            end
         end
         S_LAB_D: begin
            if (pkt_rdata == 8'h00) begin
               if (!jumped_ff) begin
                  after_in = pos_ff;
               end
               state_in = S_NEND;
            end else if ((pkt_rdata & PTR_MARK) == PTR_MARK) begin
               if (pos_ff >= fill_x) begin
                  st_go = 1'b1; state_in = S_IDLE;
               end else begin
                  pkt_raddr = pos_ff[PKT_AW-1:0];
                  pos_in    = pos_ff + POS_W'(1);
                  lab_in    = pkt_rdata[5:0];
                  state_in  = S_PTR_D;
               end
            end else if (pkt_rdata > LABEL_MAX
                  || pos_ff + POS_W'(pkt_rdata) > fill_x
                  || 10'(w_ff) + 10'(pkt_rdata) >= 10'(NAME_BYTES - 1)) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               cnt_in   = pkt_rdata[5:0];
               state_in = S_CPY;
            end
         end
         S_PTR_D: begin
            if (tgt >= fill_x || depth_ff == DEPTH_W'(POINTER_DEPTH)) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               if (!jumped_ff) begin
                  after_in  = pos_ff;
                  jumped_in = 1'b1;
               end
               depth_in = depth_ff + DEPTH_W'(1);
               pos_in   = tgt;
               seg_in   = w_ff;
               state_in = S_LAB;
            end
         end
         S_CPY: begin
            if (cnt_ff == 6'd0) begin
               nm_we    = 1'b1;
               w_in     = w_ff + LEN_W'(1);
               state_in = S_LAB;
            end else begin
               pkt_raddr = pos_ff[PKT_AW-1:0];
               pos_in    = pos_ff + POS_W'(1);
               cnt_in    = cnt_ff - 6'd1;
               state_in  = S_CPY_D;
            end
         end
         S_CPY_D: begin
            nm_we    = 1'b1;
            nm_wdata = pkt_rdata;
            w_in     = w_ff + LEN_W'(1);
            state_in = S_CPY;
         end
         S_NEND: begin
            // The dot after the last label is dropped unless a pointer
            // landed right after it.
            nlen_in = (w_ff > seg_ff) ? w_ff - LEN_W'(1) : w_ff;
            k_in    = '0;
            if (after_ff + POS_W'(4) > fill_x) begin
               st_go = 1'b1; state_in = S_IDLE;
            end else begin
               state_in = S_QT;
            end
         end
         S_QT: begin
            pkt_raddr = PKT_AW'(after_ff + POS_W'(k_ff));
            state_in  = S_QT_D;
         end
         S_QT_D: begin
            if (pkt_rdata != {7'd0, k_ff[0]}) begin
               st_go = 1'b1; st_code = ST_NOMATCH; state_in = S_IDLE;
            end else if (k_ff == LEN_W'(3)) begin
               state_in = S_LD;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = S_QT;
            end
         end
         S_LD: begin
            slot_in = '0;
            if (nlen_ff == '0) begin
               last_dot_in = 1'b0;
               q_in        = '0;
               state_in    = S_SLOT;
            end else begin
               nm_raddr = NAME_AW'(nlen_ff - LEN_W'(1));
               state_in = S_LD_D;
            end
         end
         S_LD_D: begin
            last_dot_in = nm_rdata == DOT;
            q_in        = (nm_rdata == DOT) ? nlen_ff - LEN_W'(1) : nlen_ff;
            state_in    = S_SLOT;
         end
         S_SLOT: begin
            m_in = len_in;
            k_in = '0;
            if (slot_ff >= count) begin
               st_go = 1'b1; st_code = ST_NOMATCH; state_in = S_IDLE;
            end else if (len_in == '0) begin
               slot_in = slot_ff + SLOT_W'(1);
            end else if (q_ff == len_in) begin
               off_in   = '0;
               state_in = S_CMP;
            end else if (10'(q_ff) > 10'(len_in) + 10'd1) begin
               nm_raddr = NAME_AW'(q_ff - len_in - LEN_W'(1));
               state_in = S_DOT_D;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_DOT_D: begin
            if (nm_rdata == DOT) begin
               off_in   = q_ff - m_ff;
               state_in = S_CMP;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = S_SLOT;
            end
         end
         S_CMP: begin
            if (k_ff == m_ff) begin
               state_in = S_RESP;
            end else begin
               nm_raddr  = NAME_AW'(off_ff + k_ff);
               dom_raddr = {slot_ff[SLOT_AW-1:0], k_ff[NAME_AW-1:0]};
               state_in  = S_CMP_D;
            end
         end
         S_CMP_D: begin
            if (fold(nm_rdata) != fold(dom_rdata)) begin
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = S_SLOT;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = S_CMP;
            end
         end
         S_RESP: begin
            rlen_in  = 9'(RESP_FIXED) + 9'(nlen_ff)
                     + 9'((nlen_ff != '0 && !last_dot_ff) ? 1 : 0);
            k_in     = '0;
            state_in = S_ID;
         end
         S_ID: begin
            pkt_raddr = PKT_AW'(k_ff[0]);
            state_in  = S_ID_D;
         end
         S_ID_D: begin
            push_en   = 1'b1;
            push_byte = pkt_rdata;
            if (k_ff[0]) begin
               k_in     = '0;
               state_in = S_HDR;
            end else begin
               k_in     = k_ff + LEN_W'(1);
               state_in = S_ID;
            end
         end
         S_HDR: begin
            push_en   = 1'b1;
            push_byte = hdr_byte(k_ff[3:0]);
            k_in      = k_ff + LEN_W'(1);
            if (k_ff == LEN_W'(9)) begin
               p_in     = '0;
               state_in = S_NM;
            end
         end
         S_NM: begin
            k_in = '0;
            if (p_ff >= nlen_ff) begin
               state_in = S_TL;
            end else begin
               e_in     = p_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (e_ff >= nlen_ff) begin
               state_in = S_LEN;
            end else begin
               nm_raddr = e_ff[NAME_AW-1:0];
               state_in = S_SCAN_D;
            end
         end
         S_SCAN_D: begin
            if (nm_rdata == DOT) begin
               state_in = S_LEN;
            end else begin
               e_in     = e_ff + LEN_W'(1);
               state_in = S_SCAN;
            end
         end
         S_LEN: begin
            push_en   = 1'b1;
            push_byte = 8'(e_ff - p_ff);
            state_in  = S_NCP;
         end
         S_NCP: begin
            if (p_ff == e_ff) begin
               k_in = '0;
               if (e_ff >= nlen_ff) begin
                  state_in = S_TL;
               end else begin
                  p_in     = e_ff + LEN_W'(1);
                  state_in = S_NM;
               end
            end else begin
               nm_raddr = p_ff[NAME_AW-1:0];
               state_in = S_NCP_D;
            end
         end
         S_NCP_D: begin
            push_en   = 1'b1;
            push_byte = nm_rdata;
            p_in      = p_ff + LEN_W'(1);
            state_in  = S_NCP;
         end
         S_TL: begin
            push_en   = 1'b1;
            push_byte = tail_byte(k_ff[4:0], spoof_address);
            k_in      = k_ff + LEN_W'(1);
            if (k_ff == LEN_W'(TAIL_LAST)) begin
               push_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      fill_ff <= fill_in;   over_ff <= over_in;     z4_ff <= z4_in;
      pos_ff <= pos_in;     after_ff <= after_in;   w_ff <= w_in;
      seg_ff <= seg_in;     nlen_ff <= nlen_in;     q_ff <= q_in;
      m_ff <= m_in;         off_ff <= off_in;       k_ff <= k_in;
      e_ff <= e_in;         p_ff <= p_in;           rlen_ff <= rlen_in;
      depth_ff <= depth_in; jumped_ff <= jumped_in; last_dot_ff <= last_dot_in;
      lab_ff <= lab_in;     cnt_ff <= cnt_in;       slot_ff <= slot_in;
   end

   // Byte packer: first byte lands in the top lane of the word.
   assign acc_in = acc_ff | (64'(push_byte) << {~bcnt_ff, 3'b000});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
         bcnt_ff  <= '0;
      end else begin
         valid_ff <= 1'b0;
         if (st_go) begin
            valid_ff <= 1'b1;
            word_ff  <= '0;
            bc_ff    <= 4'd0;
            fin_ff   <= 1'b1;
            stat_ff  <= st_code;
            len_ff   <= 9'd0;
         end else if (push_en) begin
            if (bcnt_ff == 3'd7 || push_last) begin
               valid_ff <= 1'b1;
               word_ff  <= acc_in;
               bc_ff    <= 4'(bcnt_ff) + 4'd1;
               fin_ff   <= push_last;
               stat_ff  <= ST_OK;
               len_ff   <= rlen_ff;
               acc_ff   <= '0;
               bcnt_ff  <= '0;
            end else begin
               acc_ff  <= acc_in;
               bcnt_ff <= bcnt_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_data_word       = word_ff;
   assign rsp_byte_count      = bc_ff;
   assign rsp_final_word      = fin_ff;
   assign rsp_status          = stat_ff;
   assign rsp_response_length = len_ff;

   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      valid_ff && stat_ff != ST_OK |-> fin_ff && bc_ff == 4'd0 && len_ff == 9'd0)
      else $error("status result carries payload");

   a_full_words: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !fin_ff |-> bc_ff == 4'd8)
      else $error("partial word before end of response");

   a_no_mix: assert property (@(posedge clock) disable iff (reset)
      st_go |-> !push_en && bcnt_ff == 3'd0)
      else $error("status raised while packing response bytes");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> active)
      else $error("request taken but engine stayed idle");

endmodule

>>> design/dns_query_filter_responder.sv
// ----------------------------------------------------------------------------
// DNS query filter responder
// Buffers DNS queries and answers A/IN queries for monitored domains.
// ----------------------------------------------------------------------------
// Flow: an oversized or short packet gets its result from the first check and
//   a zero qdcount after header bytes 4 and 5 are read; otherwise the name is
//   decoded byte by byte and label by label, each domain slot is matched by
//   comparing byte by byte, and the response is built from fixed, ID and name
//   bytes, all paced by the single read port of each buffer.
// Throughput: one request per cycle while bytes are collected; busy stays
//   high from the cycle after a packet's last byte until its final result.
// Reset clears the domain table, the packet fill and spoof_address; buffer
//   contents are left as they are and no clearing pass runs. The receiver
//   cannot stall results.
// ----------------------------------------------------------------------------
module dns_query_filter_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_mark,
   output logic        rsp_valid,
   output logic [63:0] rsp_data_word,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_final_word,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_response_length,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dqfr_pkg::*;

   localparam logic REG_SPOOF = 1'b0;

   logic               accept;
   logic [31:0]        spoof_ff;
   logic               pkt_we, dom_we, push, pop, q_empty, back_active;
   logic [PKT_AW-1:0]  pkt_waddr, pkt_raddr;
   logic [DOM_AW-1:0]  dom_waddr, dom_raddr;
   logic [7:0]         pkt_rdata, dom_rdata;
   job_type            push_job, head_job;
   logic [SLOT_AW-1:0] len_idx;
   logic [LEN_W-1:0]   len_val;
   logic [SLOT_W-1:0]  dom_count;

   // A request is taken whenever the engine has no packet in hand. Once a
   // packet's last byte is in, the queue is non-empty and busy holds off
   // new requests, since the packet buffer and the domain table are read
   // by the back end until the final result goes out.
   assign accept = start && !busy;
   assign busy   = !q_empty || back_active;

   // Configuration register: only spoof_address, at byte address zero.
   assign pready = 1'b1;
   assign prdata = (psel && paddr[2] == REG_SPOOF) ? spoof_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         spoof_ff <= 32'd0;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPOOF) begin
         spoof_ff <= pwdata;
      end
   end

   dqfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_action    (req_action),
      .req_end_mark  (req_end_mark),
      .pkt_we        (pkt_we),
      .pkt_waddr     (pkt_waddr),
      .dom_we        (dom_we),
      .dom_waddr     (dom_waddr),
      .push          (push),
      .job           (push_job),
      .len_idx       (len_idx),
      .len_out       (len_val),
      .count         (dom_count)
   );

   // Packet and domain buffers: written by the front, read by the back.
   dqfr_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
      .clock (clock),
      .we    (pkt_we),
      .waddr (pkt_waddr),
      .wdata (req_data_byte),
      .raddr (pkt_raddr),
      .rdata (pkt_rdata)
   );

   dqfr_ram #(.WIDTH(8), .DEPTH(DOM_DEPTH)) u_dom_ram (
      .clock (clock),
      .we    (dom_we),
      .waddr (dom_waddr),
      .wdata (req_data_byte),
      .raddr (dom_raddr),
      .rdata (dom_rdata)
   );

   dqfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head_job),
      .empty    (q_empty)
   );

   dqfr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_ready           (!q_empty),
      .job                 (head_job),
      .pop                 (pop),
      .active              (back_active),
      .spoof_address       (spoof_ff),
      .count               (dom_count),
      .len_idx             (len_idx),
      .len_in              (len_val),
      .pkt_raddr           (pkt_raddr),
      .pkt_rdata           (pkt_rdata),
      .dom_raddr           (dom_raddr),
      .dom_rdata           (dom_rdata),
      .rsp_valid           (rsp_valid),
      .rsp_data_word       (rsp_data_word),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_final_word      (rsp_final_word),
      .rsp_status          (rsp_status),
      .rsp_response_length (rsp_response_length)
   );

endmodule
